[hw/rtl/gml_pkg.sv]
// gml_pkg: shared types and constants of the gaussian ml pixel classifier
// used by gml_score_unit and gaussian_ml_pixel_classifier; no dependencies

package gml_pkg;

  localparam int COEF_W = 4;

  // coefficient slots within one class row of the table
  localparam logic [COEF_W-1:0] COEF_MEAN_FIRST = 4'd0;
  localparam logic [COEF_W-1:0] COEF_MEAN_LAST  = 4'd2;
  localparam logic [COEF_W-1:0] COEF_CINV_FIRST = 4'd3;
  localparam logic [COEF_W-1:0] COEF_CINV_LAST  = 4'd11;
  localparam logic [COEF_W-1:0] COEF_LOGDET     = 4'd12;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic signed [63:0] SCORE_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SCORE_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic       load_v;
    logic [1:0] v_sel;
    logic       init_acc;
    logic       mul_vv;
    logic       mul_coef;
    logic       acc_step;
    logic [1:0] row;
    logic [1:0] col;
  } score_ctrl_t;

  // row of the inverse covariance element held in a coefficient slot
  function automatic logic [1:0] term_row(input logic [COEF_W-1:0] coef);
    logic [1:0] r;
    case (coef) inside
      [4'd3:4'd5]: r = 2'd0;
      [4'd6:4'd8]: r = 2'd1;
      default:     r = 2'd2;
    endcase
    return r;
  endfunction

  // column of the inverse covariance element held in a coefficient slot
  function automatic logic [1:0] term_col(input logic [COEF_W-1:0] coef);
    logic [1:0] c;
    case (coef) inside
      4'd3, 4'd6, 4'd9:  c = 2'd0;
      4'd4, 4'd7, 4'd10: c = 2'd1;
      default:           c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/gaussian_ml_pixel_classifier.sv]
// gaussian_ml_pixel_classifier: top level, sequencer, class table and best-score tracking
// depends on gml_pkg, gml_coef_mem, gml_score_unit
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | operation red green blue last_pixel class_sel
//          |                      | coef_sel coef_value
//  out     | out_valid / out_stall| out_red out_green out_blue class_index out_last
//  cfg     | cfg_wr_en            | cfg_wr_data (class_count)
//
// a load transaction writes the table without stalling the input; a classify
// transaction is scored by the sequencer feeding one coefficient per step of the
// shared multiplier and accumulator
// rst is synchronous; it clears the sequencer, the output flag and class_count to 1
// the coefficient table is not cleared
// in_stall stays high while a pixel is being scored or its result cannot be stored

module gaussian_ml_pixel_classifier
  import gml_pkg::*;
#(
  parameter int MAX_CLASSES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               last_pixel,
  input  logic [4:0]         class_sel,
  input  logic [3:0]         coef_sel,
  input  logic signed [31:0] coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [4:0]         class_index,
  output logic               out_last
);

  localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = CLS_W + COEF_W;
  localparam int DEPTH  = MAX_CLASSES * (2 ** COEF_W);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ADDR = 9'b000000010,
    S_MEAN = 9'b000000100,
    S_LD   = 9'b000001000,
    S_VV   = 9'b000010000,
    S_CMUL = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [5:0]         class_count;
  logic [CLS_W-1:0]   cls;
  logic [CLS_W-1:0]   n_last;
  logic [CLS_W-1:0]   best;
  logic [COEF_W-1:0]  coef;
  logic [7:0]         px_r;
  logic [7:0]         px_g;
  logic [7:0]         px_b;
  logic               px_last;
  logic signed [63:0] best_score;
  logic signed [63:0] score;
  logic [31:0]        rd_data;
  logic               accept;
  logic               wr_en;
  logic [CNT_W-1:0]   sel_ext;
  logic [CNT_W-1:0]   cnt_ext;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   best_ext;
  logic               out_free;
  score_ctrl_t        ctrl;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign sel_ext = CNT_W'(class_sel);
  assign wr_en   = accept && (operation == OP_LOAD) && (sel_ext < CNT_W'(MAX_CLASSES))
                   && (coef_sel <= COEF_LOGDET);

  always_comb begin
    cnt_ext = CNT_W'(class_count);
    cnt_eff = (cnt_ext == '0) ? CNT_W'(1) : cnt_ext;
    if (cnt_eff > CNT_W'(MAX_CLASSES)) begin
      cnt_eff = CNT_W'(MAX_CLASSES);
    end
  end

  gml_coef_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({sel_ext[CLS_W-1:0], coef_sel}),
    .wr_data (coef_value),
    .rd_addr ({cls, coef}),
    .rd_data (rd_data)
  );

  always_comb begin
    ctrl.load_v   = (state == S_MEAN);
    ctrl.v_sel    = coef[1:0];
    ctrl.init_acc = (state == S_LD);
    ctrl.mul_vv   = (state == S_VV);
    ctrl.mul_coef = (state == S_CMUL);
    ctrl.acc_step = (state == S_ACC);
    ctrl.row      = term_row(coef);
    ctrl.col      = term_col(coef);
  end

  gml_score_unit u_score (
    .clk       (clk),
    .ctrl      (ctrl),
    .red       (px_r),
    .green     (px_g),
    .blue      (px_b),
    .coef_data (rd_data),
    .score     (score)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_CLASSIFY) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (coef <= COEF_MEAN_LAST) begin
          state_next = S_MEAN;
        end else if (coef == COEF_LOGDET) begin
          state_next = S_LD;
        end else begin
          state_next = S_VV;
        end
      end
      S_MEAN: state_next = S_ADDR;
      S_LD:   state_next = S_ADDR;
      S_VV:   state_next = S_CMUL;
      S_CMUL: state_next = S_ACC;
      S_ACC:  state_next = (coef == COEF_CINV_LAST) ? S_CMP : S_VV;
      S_CMP:  state_next = (cls == n_last) ? S_DONE : S_ADDR;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      class_count <= 6'd1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        class_count <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer counters, pixel registers and best-score tracking
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_CLASSIFY) begin
          px_r    <= red;
          px_g    <= green;
          px_b    <= blue;
          px_last <= last_pixel;
          n_last  <= CLS_W'(cnt_eff - CNT_W'(1));
          cls     <= '0;
          coef    <= COEF_MEAN_FIRST;
        end
      end
      S_MEAN: coef <= (coef == COEF_MEAN_LAST) ? COEF_LOGDET : coef + 1'b1;
      S_LD:   coef <= COEF_CINV_FIRST;
      S_ACC: begin
        if (coef != COEF_CINV_LAST) begin
          coef <= coef + 1'b1;
        end
      end
      S_CMP: begin
        if (cls == '0 || best_score < score) begin
          best       <= cls;
          best_score <= score;
        end
        if (cls != n_last) begin
          cls  <= cls + 1'b1;
          coef <= COEF_MEAN_FIRST;
        end
      end
      default: ;
    endcase
  end

  assign best_ext = CNT_W'(best);

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_red     <= px_r;
      out_green   <= px_g;
      out_blue    <= px_b;
      class_index <= best_ext[4:0];
      out_last    <= px_last;
    end
  end

endmodule

[hw/rtl/gml_coef_mem.sv]
// gml_coef_mem: class coefficient table, one write port, one registered read port
// no dependencies

module gml_coef_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/gml_score_unit.sv]
// gml_score_unit: per-class score datapath around one shared 32x32 multiplier
// depends on gml_pkg

module gml_score_unit
  import gml_pkg::*;
(
  input  logic                clk,
  input  score_ctrl_t         ctrl,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [31:0]         coef_data,
  output logic signed [63:0]  score
);

  logic signed [16:0] v [3];
  logic [7:0]         chan;
  logic signed [16:0] v_new;
  logic signed [16:0] vi;
  logic signed [16:0] vj;
  logic [16:0]        mag_i;
  logic [16:0]        mag_j;
  logic [31:0]        coef_mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic               neg;
  logic signed [63:0] term;
  logic signed [63:0] diff;
  logic               ovf;
  logic signed [63:0] logdet_ext;

  always_comb begin
    case (ctrl.v_sel)
      2'd0:    chan = red;
      2'd1:    chan = green;
      default: chan = blue;
    endcase
  end

  assign v_new = $signed({1'b0, chan, 8'h00}) - $signed({1'b0, coef_data[15:0]});

  assign vi    = v[ctrl.row];
  assign vj    = v[ctrl.col];
  assign mag_i = vi[16] ? 17'(-vi) : 17'(vi);
  assign mag_j = vj[16] ? 17'(-vj) : 17'(vj);
  assign coef_mag = coef_data[31] ? 32'(-coef_data) : coef_data;

  always_comb begin
    if (ctrl.mul_vv) begin
      mul_a = {16'h0000, mag_i[15:0]};
      mul_b = {16'h0000, mag_j[15:0]};
    end else begin
      mul_a = prod[31:0];
      mul_b = coef_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_v) begin
      v[ctrl.v_sel] <= v_new;
    end
  end

  // |v_i*v_j| < 2^32 and |cinv| <= 2^31, so the term magnitude stays below 2^63
  always_ff @(posedge clk) begin
    if (ctrl.mul_vv || ctrl.mul_coef) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.mul_vv) begin
      neg <= vi[16] ^ vj[16];
    end else if (ctrl.mul_coef) begin
      neg <= neg ^ coef_data[31];
    end
  end

  assign term       = neg ? -$signed(prod) : $signed(prod);
  assign diff       = score - term;
  assign ovf        = (score[63] != term[63]) && (diff[63] != score[63]);
  assign logdet_ext = {{16{coef_data[31]}}, coef_data, 16'h0000};

  always_ff @(posedge clk) begin
    if (ctrl.init_acc) begin
      score <= -logdet_ext;
    end else if (ctrl.acc_step) begin
      score <= ovf ? (score[63] ? SCORE_MIN : SCORE_MAX) : diff;
    end
  end

endmodule

[hw/rtl/gml_checker.sv]
// gml_checker: port-level checks on the classifier, bound to the top level
// depends on gaussian_ml_pixel_classifier

module gml_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [4:0] class_index,
  input logic       out_last
);

  // held result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(class_index) && $stable(out_last))
    else $error("stalled result changed");

  // a classify transaction starts scoring
  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation |=> in_stall)
    else $error("no stall after classify transaction");

  // a load transaction leaves the input unstalled in the cycle after it
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !operation |=> !in_stall)
    else $error("stall after load transaction");

  // a new result only appears from the busy sequencer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without scoring");

endmodule

bind gaussian_ml_pixel_classifier gml_checker u_gml_checker (.*);

[test/tb_top.sv]
// tb_top: self-checking testbench for gaussian_ml_pixel_classifier
// a directed coefficient and pixel table, then randomized phases of class loads and pixels,
// checked against a fixed-point likelihood predictor held here; depends on gml_pkg and the rtl
`timescale 1ns / 100ps

module tb_top
  import gml_pkg::*;
;

  localparam int NUM_CLASSES    = 32;
  localparam int NUM_COEFS      = 13;
  localparam int NUM_PHASES     = 12;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 10000;

  typedef struct {
    logic               op;
    logic [7:0]         r, g, b;
    logic               lst;
    logic [4:0]         cls;
    logic [3:0]         sel;
    logic signed [31:0] val;
  } in_txn_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic [4:0] idx;
    logic       lst;
  } pixel_result_t;

  typedef struct {
    in_txn_t    txn;
    bit         typed;
    logic [4:0] idx;
  } directed_row_t;

  typedef enum int {KIND_TAME, KIND_WILD, KIND_DRIVE_MIN, KIND_DRIVE_MAX, KIND_COPY} class_kind_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [5:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               operation;
  logic [7:0]         red, green, blue;
  logic               last_pixel;
  logic [4:0]         class_sel;
  logic [3:0]         coef_sel;
  logic signed [31:0] coef_value;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_red, out_green, out_blue;
  logic [4:0]         class_index;
  logic               out_last;

  gaussian_ml_pixel_classifier #(
    .MAX_CLASSES(NUM_CLASSES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .red(red),
    .green(green),
    .blue(blue),
    .last_pixel(last_pixel),
    .class_sel(class_sel),
    .coef_sel(coef_sel),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .class_index(class_index),
    .out_last(out_last)
  );

  // class table as the predictor sees it
  logic [15:0]        mean_q88    [NUM_CLASSES][3];
  logic signed [31:0] cinv_q16    [NUM_CLASSES][9];
  logic signed [31:0] logdet_q16  [NUM_CLASSES];
  bit                 coef_loaded [NUM_CLASSES][NUM_COEFS];
  logic [5:0]         class_count = 6'd1;

  pixel_result_t pending_pixels[$];
  pixel_result_t seen;
  int error_count  = 0;
  int quiet_cycles = 0;
  int tx_idle_pct  = 35;
  int rx_stall_pct = 58;
  int holdoff_req  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int active_classes(input logic [5:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > NUM_CLASSES) return NUM_CLASSES;
    return int'(cnt);
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [95:0] x);
    logic signed [95:0] hi, lo;
    hi = 96'(SCORE_MAX);
    lo = 96'(SCORE_MIN);
    if (x > hi) return SCORE_MAX;
    if (x < lo) return SCORE_MIN;
    return x[63:0];
  endfunction

  function automatic logic signed [63:0] class_log_likelihood(input int c,
                                                              input logic [7:0] r, g, b);
    logic [7:0]         chan [3];
    int                 dv [3];
    logic signed [63:0] acc, vv, term;
    logic signed [95:0] wa, wb;
    chan[0] = r;
    chan[1] = g;
    chan[2] = b;
    for (int i = 0; i < 3; i++)
      dv[i] = int'({chan[i], 8'd0}) - int'(mean_q88[c][i]);
    acc = -(longint'(logdet_q16[c]) * 64'sd65536);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vv = longint'(dv[i]) * longint'(dv[j]);
        wa = 96'(vv);
        wb = 96'(cinv_q16[c][i * 3 + j]);
        term = clamp64(wa * wb);
        wa = 96'(acc);
        wb = 96'(term);
        acc = clamp64(wa - wb);
      end
    end
    return acc;
  endfunction

  function automatic logic [4:0] predict_class_index(input logic [7:0] r, g, b);
    int                 n, best;
    logic signed [63:0] best_score, s;
    n = active_classes(class_count);
    best = 0;
    best_score = class_log_likelihood(0, r, g, b);
    for (int m = 1; m < n; m++) begin
      s = class_log_likelihood(m, r, g, b);
      if (best_score < s) begin
        best_score = s;
        best = m;
      end
    end
    return best[4:0];
  endfunction

  function automatic void apply_load(input in_txn_t t);
    if (t.sel <= COEF_MEAN_LAST) mean_q88[t.cls][t.sel] = t.val[15:0];
    else if (t.sel <= COEF_CINV_LAST) cinv_q16[t.cls][t.sel - COEF_CINV_FIRST] = t.val;
    else if (t.sel == COEF_LOGDET) logdet_q16[t.cls] = t.val;
    if (t.sel <= COEF_LOGDET) coef_loaded[t.cls][t.sel] = 1'b1;
  endfunction

  function automatic bit class_ready(input int c);
    for (int k = 0; k < NUM_COEFS; k++)
      if (!coef_loaded[c][k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_txn_t noise_txn();
    in_txn_t t;
    t.op  = OP_LOAD;
    t.r   = 8'($urandom);
    t.g   = 8'($urandom);
    t.b   = 8'($urandom);
    t.lst = 1'($urandom);
    t.cls = 5'($urandom);
    t.sel = 4'($urandom);
    t.val = $urandom;
    return t;
  endfunction

  function automatic logic signed [31:0] coef_for(input class_kind_t kind, input int sel,
                                                  input int src);
    logic [3:0] s;
    s = sel[3:0];
    if (kind == KIND_WILD) return $urandom;
    if (kind == KIND_COPY) begin
      if (s <= COEF_MEAN_LAST) return {16'h5A5A, mean_q88[src][s]};
      if (s <= COEF_CINV_LAST) return cinv_q16[src][s - COEF_CINV_FIRST];
      return logdet_q16[src];
    end
    if (s <= COEF_MEAN_LAST) return $urandom;
    if (kind == KIND_DRIVE_MIN) return 32'sh7FFF_FFFF;
    if (kind == KIND_DRIVE_MAX) return 32'sh8000_0000;
    if (s == COEF_LOGDET) return int'($urandom_range(40 << 16)) - (20 << 16);
    if (term_row(s) == term_col(s)) return $urandom_range(32'h2_0000, 32'h100);
    return int'($urandom_range(32'h8000)) - 32'sh4000;
  endfunction

  function automatic logic [7:0] near_channel(input logic [15:0] m);
    int v;
    v = int'(m[15:8]) + int'($urandom_range(12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic in_txn_t pixel_txn(input int n_active);
    in_txn_t t;
    int      pick, c;
    t = noise_txn();
    t.op = OP_CLASSIFY;
    t.lst = ($urandom_range(7) == 0);
    pick = $urandom_range(99);
    if (pick < 40) begin
      c = $urandom_range(n_active - 1);
      t.r = near_channel(mean_q88[c][0]);
      t.g = near_channel(mean_q88[c][1]);
      t.b = near_channel(mean_q88[c][2]);
    end else if (pick < 55) begin
      t.r = $urandom_range(1) ? 8'hFF : 8'h00;
      t.g = $urandom_range(1) ? 8'hFF : 8'h00;
      t.b = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return t;
  endfunction

  function automatic directed_row_t coef_row(input logic [4:0] c, input logic [3:0] s,
                                             input logic signed [31:0] v);
    directed_row_t d;
    d.txn = noise_txn();
    d.txn.op = OP_LOAD;
    d.txn.cls = c;
    d.txn.sel = s;
    d.txn.val = v;
    d.typed = 1'b0;
    d.idx = '0;
    return d;
  endfunction

  function automatic directed_row_t pixel_row(input logic [7:0] r, g, b, input logic lst,
                                              input logic [4:0] idx);
    directed_row_t d;
    d.txn = noise_txn();
    d.txn.op = OP_CLASSIFY;
    d.txn.r = r;
    d.txn.g = g;
    d.txn.b = b;
    d.txn.lst = lst;
    d.typed = 1'b1;
    d.idx = idx;
    return d;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_txn(input in_txn_t t, input bit typed, input logic [4:0] typed_idx);
    pixel_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= t.op;
    red        <= t.r;
    green      <= t.g;
    blue       <= t.b;
    last_pixel <= t.lst;
    class_sel  <= t.cls;
    coef_sel   <= t.sel;
    coef_value <= t.val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (t.op == OP_LOAD) begin
      apply_load(t);
    end else begin
      res.r   = t.r;
      res.g   = t.g;
      res.b   = t.b;
      res.lst = t.lst;
      res.idx = typed ? typed_idx : predict_class_index(t.r, t.g, t.b);
      pending_pixels = {pending_pixels, res};
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_class_count(input logic [5:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    class_count = value;
  endtask

  // all thirteen coefficients of one class, in shuffled order
  task automatic load_class(input int c);
    int                 order [NUM_COEFS];
    logic signed [31:0] vals [NUM_COEFS];
    class_kind_t        kind;
    int                 pick, src, k, tmp;
    in_txn_t            t;
    pick = $urandom_range(99);
    if (pick < 60) kind = KIND_TAME;
    else if (pick < 75) kind = KIND_WILD;
    else if (pick < 83) kind = KIND_DRIVE_MIN;
    else if (pick < 88) kind = KIND_DRIVE_MAX;
    else kind = KIND_COPY;
    src = $urandom_range(NUM_CLASSES - 1);
    if (!class_ready(src)) src = 0;
    for (int s = 0; s < NUM_COEFS; s++) begin
      order[s] = s;
      vals[s] = coef_for(kind, s, src);
    end
    for (int s = NUM_COEFS - 1; s > 0; s--) begin
      k = $urandom_range(s);
      tmp = order[s];
      order[s] = order[k];
      order[k] = tmp;
    end
    foreach (order[s]) begin
      t = noise_txn();
      t.cls = 5'(c);
      t.sel = 4'(order[s]);
      t.val = vals[order[s]];
      send_txn(t, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int phase, input logic [5:0] count_val);
    int      n_eff, n_items, pick;
    in_txn_t t;
    tx_idle_pct  = (phase < 4) ? 35 : ((phase < 8) ? 58 : 0);
    rx_stall_pct = (phase < 4) ? 58 : ((phase < 8) ? 35 : 0);
    write_class_count(count_val);
    n_eff = active_classes(count_val);
    for (int c = 0; c < n_eff; c++)
      if (!class_ready(c)) load_class(c);
    if (phase == 2) holdoff_req = HOLDOFF_CYCLES;
    n_items = (n_eff > 16) ? 4 : 10;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_txn(pixel_txn(n_eff), 1'b0, '0);
      end else if (pick < 85) begin
        t = noise_txn();
        t.sel = 4'($urandom_range(COEF_LOGDET));
        if ($urandom_range(1)) t.val = coef_for(KIND_TAME, int'(t.sel), 0);
        send_txn(t, 1'b0, '0);
      end else if (pick < 97) begin
        t = noise_txn();
        t.sel = 4'($urandom_range(4'hF, COEF_LOGDET + 1));
        send_txn(t, 1'b0, '0);
      end else begin
        load_class($urandom_range(NUM_CLASSES - 1));
      end
    end
  endtask

  // receiver side
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req != 0) begin
        hold_left = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("pixel transaction with nothing pending");
      end else begin
        seen = pending_pixels.pop_front();
        if (out_red !== seen.r)
          flag_mismatch($sformatf("out_red %0d, expected %0d", out_red, seen.r));
        if (out_green !== seen.g)
          flag_mismatch($sformatf("out_green %0d, expected %0d", out_green, seen.g));
        if (out_blue !== seen.b)
          flag_mismatch($sformatf("out_blue %0d, expected %0d", out_blue, seen.b));
        if (class_index !== seen.idx)
          flag_mismatch($sformatf("class_index %0d, expected %0d", class_index, seen.idx));
        if (out_last !== seen.lst)
          flag_mismatch($sformatf("out_last %0d, expected %0d", out_last, seen.lst));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    directed_row_t      rows[$];
    logic signed [31:0] cinv_edge [9];
    int                 count_plan [NUM_PHASES];
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    operation   = OP_LOAD;
    red         = '0;
    green       = '0;
    blue        = '0;
    last_pixel  = 1'b0;
    class_sel   = '0;
    coef_sel    = '0;
    coef_value  = '0;
    cinv_edge  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh1, -32'sh1,
                   32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0002_0000};
    count_plan = '{0, 3, 2, 6, 32, 1, 5, 63, 4, 40, 7, 2};

    // class 0 at the extremes; class count is 1 after reset so every pixel maps to 0
    rows = {rows, coef_row(5'd0, COEF_MEAN_FIRST, 32'sh1234_FFFF)};
    rows = {rows, coef_row(5'd0, 4'(COEF_MEAN_FIRST + 1), 32'sh0)};
    rows = {rows, coef_row(5'd0, COEF_MEAN_LAST, 32'shFFFF_8000)};
    for (int k = 0; k < 9; k++)
      rows = {rows, coef_row(5'd0, 4'(COEF_CINV_FIRST + k), cinv_edge[k])};
    rows = {rows, coef_row(5'd0, COEF_LOGDET, 32'sh8000_0000)};
    rows = {rows, coef_row(5'd0, 4'(COEF_LOGDET + 1), 32'sh7FFF_FFFF)};
    rows = {rows, coef_row(5'd31, 4'(COEF_LOGDET + 2), 32'sh0)};
    rows = {rows, coef_row(5'd0, 4'(COEF_LOGDET + 3), -32'sh1)};
    rows = {rows, coef_row(5'd31, COEF_LOGDET, 32'sh7FFF_FFFF)};
    rows = {rows, pixel_row(8'd0, 8'd0, 8'd0, 1'b0, 5'd0)};
    rows = {rows, pixel_row(8'd255, 8'd255, 8'd255, 1'b1, 5'd0)};
    rows = {rows, pixel_row(8'd255, 8'd0, 8'd128, 1'b1, 5'd0)};
    rows = {rows, pixel_row(8'd0, 8'd255, 8'd0, 1'b0, 5'd0)};
    rows = {rows, pixel_row(8'd128, 8'd64, 8'd200, 1'b0, 5'd0)};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_txn(rows[i].txn, rows[i].typed, rows[i].idx);
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p, 6'(count_plan[p]));
    wait_drained();

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hw/rtl/gml_pkg.sv
hw/rtl/gml_coef_mem.sv
hw/rtl/gml_score_unit.sv
hw/rtl/gaussian_ml_pixel_classifier.sv
hw/rtl/gml_checker.sv
test/tb_top.sv
